// File: src/exact_unit_distance_pair_test_assert.svh
// Assertion macros for the unit distance pair test.
`ifndef EXACT_UNIT_DISTANCE_PAIR_TEST_ASSERT_SVH
`define EXACT_UNIT_DISTANCE_PAIR_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define EUD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EUD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EUD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EUD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/eudpt_pkg.sv
// Package: shared types and constants for the unit distance pair test.
package eudpt_pkg;
    localparam int unsigned MAX_POINTS = 16384;
    localparam int unsigned IDX_W = $clog2(MAX_POINTS);
    localparam int unsigned W     = 128;
    typedef logic signed [W-1:0] t_wide;
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_DEN  = 3'd0;
    localparam t_reg_idx REG_SD   = 3'd1;
    localparam t_reg_idx REG_S0   = 3'd2;
    localparam t_reg_idx REG_S1   = 3'd3;
    localparam t_reg_idx REG_MODE = 3'd4;
    typedef struct packed {
        logic               mode;
        logic signed [30:0] sd;
        logic signed [31:0] s0;
        logic signed [31:0] s1;
        logic signed [30:0] den;
    } t_cfg;
endpackage

// File: src/eudpt_if.sv
// Interfaces: pair input channel and edge result channel.
interface eudpt_pair_if import eudpt_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [31:0] dx_one, dx_root33, dx_root3, dx_root11;
    logic signed [31:0] dy_one, dy_root33, dy_root3, dy_root11;
    logic [IDX_W-1:0] first_index, second_index;
    modport source (output valid, dx_one, dx_root33, dx_root3, dx_root11,
        dy_one, dy_root33, dy_root3, dy_root11, first_index, second_index,
        input ready);
    modport sink (input valid, dx_one, dx_root33, dx_root3, dx_root11,
        dy_one, dy_root33, dy_root3, dy_root11, first_index, second_index,
        output ready);
endinterface

interface eudpt_edge_if import eudpt_pkg::*; ();
    logic valid;
    logic ready;
    logic is_edge;
    logic [IDX_W-1:0] edge_first, edge_second;
    modport source (output valid, is_edge, edge_first, edge_second, input ready);
    modport sink (input valid, is_edge, edge_first, edge_second, output ready);
endinterface

// File: src/eudpt_mul.sv
// Registered signed multiplier, one result per enabled cycle.
module eudpt_mul import eudpt_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [AW-1:0]  i_a,
    input  logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0] o_p
);
    logic signed [AW+BW-1:0] r_p;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end
    assign o_p = r_p;
endmodule

// File: src/eudpt_core.sv
// Pipelined datapath: terms, sums, register-weighted products, compares.
module eudpt_core import eudpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_cfg             i_cfg,
    input  logic signed [31:0] i_v [8],
    input  logic [IDX_W-1:0] i_fi,
    input  logic [IDX_W-1:0] i_si,
    output logic             o_valid,
    output logic             o_edge,
    output logic [IDX_W-1:0] o_fi,
    output logic [IDX_W-1:0] o_si
);
    localparam int S = 8;
    logic [S-1:0]     r_vld;
    logic [IDX_W-1:0] r_fi [S];
    logic [IDX_W-1:0] r_si [S];
    // Stage 0: scaled operands (mode 1 uses 3x copies; 34 bits fit)
    logic signed [33:0] r_z [8];
    logic signed [33:0] n_z [8];
    always_comb begin
        for (int k = 0; k < 8; k++) n_z[k] = 34'(i_v[k]);
        if (i_cfg.mode) begin
            n_z[0] = 34'(i_v[0]) * 34'sd3; n_z[1] = 34'(i_v[1]) * 34'sd3;
            n_z[2] = 34'(i_v[4]) * 34'sd3; n_z[3] = 34'(i_v[5]) * 34'sd3;
            n_z[4] = 34'(i_v[2]) * 34'sd3; n_z[5] = 34'(i_v[3]);
            n_z[6] = 34'(i_v[6]) * 34'sd3; n_z[7] = 34'(i_v[7]);
        end
    end
    // Stage 1: pairwise products. p[0..15]
    logic signed [67:0] r_p [16];
    logic signed [33:0] n_pa [16];
    logic signed [33:0] n_pb [16];
    always_comb begin
        // mode0: a..d=z0..3, A..D=z4..7 ; mode1: x=z0..3, y=z4..7
        n_pa[0]=r_z[0]; n_pb[0]=r_z[0];  n_pa[1]=r_z[1]; n_pb[1]=r_z[1];
        n_pa[2]=r_z[2]; n_pb[2]=r_z[2];  n_pa[3]=r_z[3]; n_pb[3]=r_z[3];
        n_pa[4]=r_z[4]; n_pb[4]=r_z[4];  n_pa[5]=r_z[5]; n_pb[5]=r_z[5];
        n_pa[6]=r_z[6]; n_pb[6]=r_z[6];  n_pa[7]=r_z[7]; n_pb[7]=r_z[7];
        n_pa[8]=r_z[0]; n_pb[8]=r_z[1];  n_pa[9]=r_z[2]; n_pb[9]=r_z[3];
        n_pa[10]=r_z[4]; n_pb[10]=r_z[5]; n_pa[11]=r_z[6]; n_pb[11]=r_z[7];
        if (i_cfg.mode) begin
            // x0x2, x1x3, x0x3, x1x2 ; y alike
            n_pa[12]=r_z[0]; n_pb[12]=r_z[2]; n_pa[13]=r_z[1]; n_pb[13]=r_z[3];
            n_pa[14]=r_z[0]; n_pb[14]=r_z[3]; n_pa[15]=r_z[1]; n_pb[15]=r_z[2];
        end else begin
            // aA, bB, cC, dD ; cross sums need more: aB bA cD dC in extra set
            n_pa[12]=r_z[0]; n_pb[12]=r_z[4]; n_pa[13]=r_z[1]; n_pb[13]=r_z[5];
            n_pa[14]=r_z[2]; n_pb[14]=r_z[6]; n_pa[15]=r_z[3]; n_pb[15]=r_z[7];
        end
    end
    logic signed [67:0] r_q [4];
    logic signed [33:0] n_qa [4];
    logic signed [33:0] n_qb [4];
    always_comb begin
        if (i_cfg.mode) begin
            n_qa[0]=r_z[4]; n_qb[0]=r_z[6]; n_qa[1]=r_z[5]; n_qb[1]=r_z[7];
            n_qa[2]=r_z[4]; n_qb[2]=r_z[7]; n_qa[3]=r_z[5]; n_qb[3]=r_z[6];
        end else begin
            n_qa[0]=r_z[0]; n_qb[0]=r_z[5]; n_qa[1]=r_z[1]; n_qb[1]=r_z[4];
            n_qa[2]=r_z[2]; n_qb[2]=r_z[7]; n_qa[3]=r_z[3]; n_qb[3]=r_z[6];
        end
    end
    for (genvar g = 0; g < 16; g++) begin : g_p
        eudpt_mul #(.AW(34), .BW(34)) u_m (.i_clk, .i_en, .i_a(n_pa[g]),
            .i_b(n_pb[g]), .o_p(r_p[g]));
    end
    for (genvar g = 0; g < 4; g++) begin : g_q
        eudpt_mul #(.AW(34), .BW(34)) u_m (.i_clk, .i_en, .i_a(n_qa[g]),
            .i_b(n_qb[g]), .o_p(r_q[g]));
    end
    // Stage 2: linear sums (fit in 76 bits)
    logic signed [75:0] r_u [8];
    logic signed [75:0] n_u [8];
    logic signed [75:0] p [16];
    logic signed [75:0] q [4];
    always_comb begin
        for (int k = 0; k < 16; k++) p[k] = 76'(r_p[k]);
        for (int k = 0; k < 4; k++) q[k] = 76'(r_q[k]);
        if (i_cfg.mode) begin
            // u0..3 from x, u4..7 from y: A=z0^2+33z1^2, Bv=z2^2+33z3^2, C=z2z3, E=z0z1
            n_u[0] = p[0] + 76'sd33 * p[1];
            n_u[1] = p[2] + 76'sd33 * p[3];
            n_u[2] = p[12] + 76'sd33 * p[13];
            n_u[3] = p[14] + p[15];
            n_u[4] = p[4] + 76'sd33 * p[5];
            n_u[5] = p[6] + 76'sd33 * p[7];
            n_u[6] = q[0] + 76'sd33 * q[1];
            n_u[7] = q[2] + q[3];
        end else begin
            n_u[0] = p[12] + 76'sd33 * p[13] + 76'sd3 * p[14] + 76'sd11 * p[15];
            n_u[1] = q[0] + q[1] + q[2] + q[3];
            n_u[2] = p[0] + 76'sd33 * p[1] + 76'sd3 * p[2] + 76'sd11 * p[3];
            n_u[3] = 76'sd2 * (p[8] + p[9]);
            n_u[4] = p[4] + 76'sd33 * p[5] + 76'sd3 * p[6] + 76'sd11 * p[7];
            n_u[5] = 76'sd2 * (p[10] + p[11]);
            n_u[6] = '0;
            n_u[7] = '0;
        end
    end
    logic signed [75:0] r_e [4];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
            r_e[0] <= p[8]; r_e[1] <= p[9]; r_e[2] <= p[10]; r_e[3] <= p[11];
        end
    end
    // Stage 3: combine x and y parts, weight by registers later
    // mode1: Sa=ax+3ay, Sb=bx+3by, Sc=cx+3cy (z2z3), Se=ex+3ey (z0z1), S2,S3
    logic signed [77:0] r_w [6];
    logic signed [77:0] n_w [6];
    always_comb begin
        if (i_cfg.mode) begin
            n_w[0] = 78'(r_u[0]) + 78'sd3 * 78'(r_u[4]);
            n_w[1] = 78'(r_u[1]) + 78'sd3 * 78'(r_u[5]);
            n_w[2] = 78'(r_e[1]) + 78'sd3 * 78'(r_e[3]);
            n_w[3] = 78'(r_e[0]) + 78'sd3 * 78'(r_e[2]);
            n_w[4] = 78'(r_u[2]) + 78'sd3 * 78'(r_u[6]);
            n_w[5] = 78'(r_u[3]) + 78'sd3 * 78'(r_u[7]);
        end else begin
            n_w[0] = 78'(r_u[2]); n_w[1] = 78'(r_u[3]);
            n_w[2] = 78'(r_u[4]); n_w[3] = 78'(r_u[5]);
            n_w[4] = 78'(r_u[0]); n_w[5] = 78'(r_u[1]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_w <= n_w;
    end
    // Stage 4: eight register-by-weight products, each as three 32 x 27 slices
    // mode1: sd*Sa, s0*Sb, s1*Sc, sd*Se, s0*Sc, s1*Sb, sd*S2, sd*S3
    // mode0: sd*n0, s0*N0, s1*N1, sd*n1, s0*N1, s1*N0, 1*t1, 1*t2
    logic signed [31:0] sd32;
    logic signed [31:0] n_c [8];
    logic signed [77:0] n_ws [8];
    logic signed [26:0] n_sl [8][3];
    logic signed [58:0] r_pp [8][3];
    always_comb begin
        sd32 = 32'(i_cfg.sd);
        if (i_cfg.mode) begin
            n_c[0] = sd32;     n_ws[0] = r_w[0];
            n_c[1] = i_cfg.s0; n_ws[1] = r_w[1];
            n_c[2] = i_cfg.s1; n_ws[2] = r_w[2];
            n_c[3] = sd32;     n_ws[3] = r_w[3];
            n_c[4] = i_cfg.s0; n_ws[4] = r_w[2];
            n_c[5] = i_cfg.s1; n_ws[5] = r_w[1];
            n_c[6] = sd32;     n_ws[6] = r_w[4];
            n_c[7] = sd32;     n_ws[7] = r_w[5];
        end else begin
            n_c[0] = sd32;     n_ws[0] = r_w[0];
            n_c[1] = i_cfg.s0; n_ws[1] = r_w[2];
            n_c[2] = i_cfg.s1; n_ws[2] = r_w[3];
            n_c[3] = sd32;     n_ws[3] = r_w[1];
            n_c[4] = i_cfg.s0; n_ws[4] = r_w[3];
            n_c[5] = i_cfg.s1; n_ws[5] = r_w[2];
            n_c[6] = 32'sd1;   n_ws[6] = r_w[4];
            n_c[7] = 32'sd1;   n_ws[7] = r_w[5];
        end
        // two unsigned low slices, signed top slice
        for (int j = 0; j < 8; j++) begin
            n_sl[j][0] = {1'b0, n_ws[j][25:0]};
            n_sl[j][1] = {1'b0, n_ws[j][51:26]};
            n_sl[j][2] = {n_ws[j][77], n_ws[j][77:52]};
        end
    end
    for (genvar j = 0; j < 8; j++) begin : g_pp
        for (genvar s = 0; s < 3; s++) begin : g_sl
            eudpt_mul #(.AW(32), .BW(27)) u_m (.i_clk, .i_en, .i_a(n_c[j]),
                .i_b(n_sl[j][s]), .o_p(r_pp[j][s]));
        end
    end
    // Stage 5: reassemble each product from its slices
    logic signed [110:0] r_pr [8];
    logic signed [110:0] n_pr [8];
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            n_pr[j] = 111'(r_pp[j][0]) + (111'(r_pp[j][1]) <<< 26)
                + (111'(r_pp[j][2]) <<< 52);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_pr <= n_pr;
    end
    // Stage 6: q0 / q1 sums (norm test: last two equations); S2, S3 pass on
    logic signed [110:0] r_m [4];
    logic signed [110:0] n_m [4];
    always_comb begin
        if (i_cfg.mode) begin
            n_m[0] = r_pr[0] + r_pr[1] + 111'sd66 * r_pr[2];
            n_m[1] = 111'sd2 * (r_pr[3] + r_pr[4]) + r_pr[5];
        end else begin
            n_m[0] = r_pr[0] + r_pr[1] + 111'sd33 * r_pr[2];
            n_m[1] = r_pr[3] + r_pr[4] + r_pr[5];
        end
        n_m[2] = r_pr[6];
        n_m[3] = r_pr[7];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_m <= n_m;
    end
    // Target sd*den^2, times 9 for the real test. The user must change registers only
    // while nothing is in flight (the block does not enforce it), so these free-running stages settle in time.
    logic [59:0]         r_dd;
    logic [59:0]         r_tl;
    logic [59:0]         r_th;
    logic [110:0]        n_tg;
    logic signed [110:0] r_tgt;
    always_comb begin
        n_tg = 111'(r_tl) + (111'(r_th) << 30);
        if (i_cfg.mode) n_tg = (n_tg << 3) + n_tg;
    end
    always_ff @(posedge i_clk) begin
        r_dd  <= 60'(i_cfg.den[29:0]) * 60'(i_cfg.den[29:0]);
        r_tl  <= 60'(i_cfg.sd[29:0]) * 60'(r_dd[29:0]);
        r_th  <= 60'(i_cfg.sd[29:0]) * 60'(r_dd[59:30]);
        r_tgt <= signed'(n_tg);
    end
    // Stage 7: compare
    logic r_edge;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_edge <= (r_m[0] == r_tgt) && (r_m[1] == '0) && (r_m[2] == '0)
                && (r_m[3] == '0);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[S-2:0], i_valid};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fi[0] <= i_fi; r_si[0] <= i_si;
            for (int k = 1; k < S; k++) begin
                r_fi[k] <= r_fi[k-1]; r_si[k] <= r_si[k-1];
            end
            r_z <= n_z;
        end
    end
    assign o_valid = r_vld[S-1];
    assign o_edge  = r_edge;
    assign o_fi    = r_fi[S-1];
    assign o_si    = r_si[S-1];
endmodule

// File: src/exact_unit_distance_pair_test.sv
// Top level: APB register file, pair pipeline, output skid register.
// An accepted pair beat passes the core stages and then the output register to become its result beat.
// Throughput: one pair per cycle while the pipeline advances; 8 core stages plus the output register.
// The pipeline advances when the output register is free or being taken.
// Reset (synchronous, active low) clears valid bits and restores registers:
// den=1, sd=1, s0=0, s1=0, mode=0.
`include "exact_unit_distance_pair_test_assert.svh"
module exact_unit_distance_pair_test import eudpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eudpt_pair_if.sink  s_pair,
    eudpt_edge_if.source m_edge,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg r_cfg;
    t_reg_idx w_idx;
    logic w_en;
    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_en   = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.den <= 31'sd1; r_cfg.sd <= 31'sd1;
            r_cfg.s0 <= '0; r_cfg.s1 <= '0; r_cfg.mode <= 1'b0;
        end else if (w_en) begin
            case (w_idx)
                REG_DEN:  r_cfg.den  <= {1'b0, pwdata[29:0]};
                REG_SD:   r_cfg.sd   <= {1'b0, pwdata[29:0]};
                REG_S0:   r_cfg.s0   <= 32'(signed'(pwdata[30:0]));
                REG_S1:   r_cfg.s1   <= 32'(signed'(pwdata[30:0]));
                REG_MODE: r_cfg.mode <= pwdata[0];
                default:  ;
            endcase
        end
    end
    always_comb begin
        case (w_idx)
            REG_DEN:  prdata = 32'(r_cfg.den[29:0]);
            REG_SD:   prdata = 32'(r_cfg.sd[29:0]);
            REG_S0:   prdata = 32'(r_cfg.s0[30:0]);
            REG_S1:   prdata = 32'(r_cfg.s1[30:0]);
            REG_MODE: prdata = 32'(r_cfg.mode);
            default:  prdata = '0;
        endcase
    end

    // Pipeline moves whenever the output register can take a beat.
    logic w_adv, w_pv, w_pe;
    logic [IDX_W-1:0] w_pf, w_ps;
    logic signed [31:0] w_v [8];
    logic r_ov, r_oe;
    logic [IDX_W-1:0] r_of, r_os;
    assign w_adv = !r_ov || m_edge.ready;
    assign s_pair.ready = w_adv;
    assign w_v[0] = s_pair.dx_one;  assign w_v[1] = s_pair.dx_root33;
    assign w_v[2] = s_pair.dx_root3; assign w_v[3] = s_pair.dx_root11;
    assign w_v[4] = s_pair.dy_one;  assign w_v[5] = s_pair.dy_root33;
    assign w_v[6] = s_pair.dy_root3; assign w_v[7] = s_pair.dy_root11;

    eudpt_core u_core (
        .i_clk, .i_rst_n, .i_en(w_adv), .i_valid(s_pair.valid), .i_cfg(r_cfg),
        .i_v(w_v), .i_fi(s_pair.first_index), .i_si(s_pair.second_index),
        .o_valid(w_pv), .o_edge(w_pe), .o_fi(w_pf), .o_si(w_ps)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_pv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oe <= w_pe;
            r_of <= w_pf;
            r_os <= w_ps;
        end
    end
    assign m_edge.valid       = r_ov;
    assign m_edge.is_edge     = r_oe;
    assign m_edge.edge_first  = r_of;
    assign m_edge.edge_second = r_os;

    `EUD_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ov && !m_edge.ready, r_ov && $stable(r_of))
    `EUD_ASSERT_IMP(a_rdy, i_clk, i_rst_n, !r_ov, s_pair.ready)
    `EUD_ASSERT_NXT(a_take, i_clk, i_rst_n, w_pv && w_adv, r_ov)
endmodule
